/* sv/bmp565_pkg.sv */
// Shared types, constants and the RGB565 packing function for the BMP pixel converter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bmp565_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int DIM_W      = 11;
    localparam int SLOT_W     = 8;
    localparam int PIX_W      = 32;
    localparam int PAL_W      = 24;
    localparam int PAL_DEPTH  = 256;
    localparam int WORD_W     = 16;
    localparam int IDX_W      = 20;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_PIXEL_MODE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Input word kinds, carried on tuser.
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_PIXEL   = 1'b1;

    typedef enum logic [1:0] {
        MODE_INDEXED = 2'd0,
        MODE_RGB565  = 2'd1,
        MODE_BGR24   = 2'd2,
        MODE_BGRX32  = 2'd3
    } t_pixel_mode;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [PAL_W-1:0]  rgb;
    } t_pal_wr;

    // Bytes b0 b1 b2 (lowest first) become b2[7:3], b1[7:2], b0[7:3].
    function automatic logic [WORD_W-1:0] pack565(input logic [PAL_W-1:0] b);
        return {b[23:19], b[15:10], b[7:3]};
    endfunction

endpackage

`default_nettype wire

/* sv/bmp_pixels_to_rgb565.sv */
// BMP pixel stream to RGB565 frame-buffer word converter, top level.
// Depends on bmp565_pkg and bmp565_palette.
//
// Input words arrive on the s_ channel. tuser selects the kind: a palette write loads
// entry palette_slot with the low three bytes of pixel_bytes and gives no output; a pixel
// gives exactly one output word on the m_ channel, in arrival order. Pixels come in file
// order, bottom row first, with source row padding already removed.
// Each output carries the RGB565 value and its destination word offset (rows flipped,
// pitch equal to the width rounded up to four pixels); tlast marks the last pixel of the
// image, after which the row and column counters start again at zero.
// The APB port sets the pixel mode, width and height; a width or height write restarts
// the image. Write registers only while no pixel is in flight.
// A pixel passes three registered stages from acceptance to the m_ channel: the palette
// read, the row offset multiplication, and the output register.
// One word is accepted per cycle while s_tready is high; the palette memory has one read
// and one write port, so neither a pixel lookup nor a palette load holds the stream.
// While m_tready is low the three stages keep filling, so s_tready falls only once all
// three hold a word. Reset empties the stages, clears the counters and resets the registers;
// the palette contents are not cleared and must be written before indexed pixels use it.
`default_nettype none

module bmp_pixels_to_rgb565 import bmp565_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // palette_slot [7:0], pixel_bytes [39:8]
    input  wire logic                  s_tuser,  // command
    // Output stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,  // rgb565_word [15:0], dest_index [35:16],
                                                 // zero [39:36]
    output logic                       m_tlast,  // last_pixel
    // Configuration.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WD_W    = $clog2(MAX_WIDTH + 1);
    localparam int HT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int PITCH_W = $clog2(MAX_WIDTH + 4);
    localparam int PROD_W  = ROW_W + PITCH_W;
    localparam int SUM_W   = (PROD_W + 1 > IDX_W) ? PROD_W + 1 : IDX_W;

    // Configuration registers.
    t_pixel_mode      r_mode;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    // Position counters.
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic              cfg_wr;
    logic [1:0]        cfg_reg;
    logic [WD_W-1:0]   w_eff;
    logic [HT_W-1:0]   h_eff;
    logic [PITCH_W-1:0] pitch;
    logic              col_last;
    logic              row_last;
    logic [ROW_W-1:0]  row_sel;

    logic s_accept;
    logic pix_accept;
    logic en1, en2, en_out;

    logic [SLOT_W-1:0] in_slot;
    logic [PIX_W-1:0]  in_bytes;

    t_pal_wr          pal_wr;
    logic [PAL_W-1:0] pal_rgb;

    // Stage 1: palette read in flight.
    logic               r1_valid;
    t_pixel_mode        r1_mode;
    logic [PAL_W-1:0]   r1_bytes;
    logic [ROW_W-1:0]   r1_row_sel;
    logic [PITCH_W-1:0] r1_pitch;
    logic [COL_W-1:0]   r1_col;
    logic               r1_last;

    // Stage 2: converted word and row offset.
    logic              r2_valid;
    logic [WORD_W-1:0] r2_word;
    logic [PROD_W-1:0] r2_prod;
    logic [COL_W-1:0]  r2_col;
    logic              r2_last;
    logic [WORD_W-1:0] s1_word;

    // Output register.
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_last;

    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_bytes = s_tdata[SLOT_W +: PIX_W];

    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_reg = paddr[3:2];
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_reg)
            REG_PIXEL_MODE:   prdata = APB_DATA_W'(r_mode);
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    // Zero is taken as one and anything above the maximum as the maximum.
    always_comb begin
        if (r_width == '0) begin
            w_eff = WD_W'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = WD_W'(MAX_WIDTH);
        end else begin
            w_eff = WD_W'(r_width);
        end
        if (r_height == '0) begin
            h_eff = HT_W'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            h_eff = HT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HT_W'(r_height);
        end
    end

    assign pitch    = (PITCH_W'(w_eff) + PITCH_W'(3)) & ~PITCH_W'(3);
    assign col_last = (WD_W'(r_col) + WD_W'(1)) >= w_eff;
    assign row_last = (HT_W'(r_row) + HT_W'(1)) >= h_eff;
    assign row_sel  = ROW_W'(h_eff - HT_W'(1) - HT_W'(r_row));

    // Each stage moves on when the one after it is empty or moving.
    assign en_out     = ~r_out_valid | m_tready;
    assign en2        = ~r2_valid | en_out;
    assign en1        = ~r1_valid | en2;
    assign s_tready   = en1;
    assign s_accept   = s_tvalid & s_tready;
    assign pix_accept = s_accept & (s_tuser == CMD_PIXEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_INDEXED;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (cfg_wr) begin
            unique case (cfg_reg)
                REG_PIXEL_MODE:   r_mode   <= t_pixel_mode'(pwdata[1:0]);
                REG_IMAGE_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr && (cfg_reg == REG_IMAGE_WIDTH || cfg_reg == REG_IMAGE_HEIGHT)) begin
            n_col = '0;
            n_row = '0;
        end else if (pix_accept) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign pal_wr.en   = s_accept & (s_tuser == CMD_PALETTE);
    assign pal_wr.slot = in_slot;
    assign pal_wr.rgb  = in_bytes[PAL_W-1:0];

    bmp565_palette u_palette (
        .i_clk     (i_clk),
        .i_wr      (pal_wr),
        .i_rd_en   (pix_accept),
        .i_rd_slot (in_bytes[SLOT_W-1:0]),
        .o_rd_rgb  (pal_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r1_valid <= pix_accept;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
            if (en_out) begin
                r_out_valid <= r2_valid;
            end
        end
    end

    always_comb begin
        unique case (r1_mode)
            MODE_INDEXED: s1_word = pack565(pal_rgb);
            MODE_RGB565:  s1_word = r1_bytes[WORD_W-1:0];
            MODE_BGR24:   s1_word = pack565(r1_bytes);
            MODE_BGRX32:  s1_word = pack565(r1_bytes);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_mode    <= r_mode;
            r1_bytes   <= in_bytes[PAL_W-1:0];
            r1_row_sel <= row_sel;
            r1_pitch   <= pitch;
            r1_col     <= r_col;
            r1_last    <= col_last & row_last;
        end
        if (en2) begin
            r2_word <= s1_word;
            r2_prod <= PROD_W'(r1_row_sel) * PROD_W'(r1_pitch);
            r2_col  <= r1_col;
            r2_last <= r1_last;
        end
        if (en_out) begin
            r_out_word <= r2_word;
            r_out_idx  <= IDX_W'(SUM_W'(r2_prod) + SUM_W'(r2_col));
            r_out_last <= r2_last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(M_TDATA_W - IDX_W - WORD_W)'(0), r_out_idx, r_out_word};
    assign m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WD_W'(r_col) < w_eff)
        else $error("column counter outside the image width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HT_W'(r_row) < h_eff)
        else $error("row counter outside the image height");

    a_geom_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && (cfg_reg == REG_IMAGE_WIDTH || cfg_reg == REG_IMAGE_HEIGHT)
        |=> r_col == '0 && r_row == '0)
        else $error("geometry write did not restart the image");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid && !en2 |=> r1_valid && $stable(pal_rgb))
        else $error("stalled palette read stage lost its word");
`endif

endmodule

`default_nettype wire

/* sv/bmp565_palette.sv */
// Palette memory of the BMP pixel converter: 256 colour entries, one write port and one
// synchronous read port. Depends on bmp565_pkg.
`default_nettype none

module bmp565_palette import bmp565_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_pal_wr           i_wr,
    input  wire logic              i_rd_en,
    input  wire logic [SLOT_W-1:0] i_rd_slot,
    output logic      [PAL_W-1:0]  o_rd_rgb
);

    logic [PAL_W-1:0] r_mem [PAL_DEPTH];
    logic [PAL_W-1:0] r_rd_rgb;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.slot] <= i_wr.rgb;
        end
    end

    // The read data holds while the stage that consumes it is stalled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_rgb <= r_mem[i_rd_slot];
        end
    end

    assign o_rd_rgb = r_rd_rgb;

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bmp_pixels_to_rgb565: palette loads and pixel words go
// in on the s_ stream, and each RGB565 word out is compared with a model kept here.
// Depends on bmp565_pkg and the RTL of the block only.

module tb;
    import bmp565_pkg::*;

    localparam int          LIMIT_W    = DEF_MAX_WIDTH;
    localparam int          LIMIT_H    = DEF_MAX_HEIGHT;
    localparam int          STALL_MAX  = 2000;
    localparam logic [1:0]  REG_UNUSED = 2'd3;

    typedef struct {
        logic        cmd;
        logic [7:0]  slot;
        logic [31:0] bytes;
    } t_src_item;

    typedef struct {
        logic [15:0] rgb;
        logic [19:0] idx;
        logic        last;
    } t_fb_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Image settings and counters as the block should hold them.
    t_pixel_mode  cfg_mode = MODE_INDEXED;
    logic [10:0]  cfg_width = 11'd1;
    logic [10:0]  cfg_height = 11'd1;
    int unsigned  col_cnt = 0;
    int unsigned  row_cnt = 0;
    logic [23:0]  pal_mem [256];
    bit           pal_known [256];
    logic [7:0]   pal_slots [$];

    t_src_item    src_items [$];
    t_fb_word     due_words [$];
    t_src_item    held_item;
    t_fb_word     want;
    bit           item_held = 1'b0;
    int           src_gap = 0;
    int           snk_gap = 0;
    int           idle_pct = 0;
    int           stall_cnt = 0;
    int           fail_count = 0;
    int           n_pixels = 0;
    int           n_palette = 0;
    int           n_last = 0;
    int           n_settings = 0;

    bmp_pixels_to_rgb565 u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // palette_slot [7:0], pixel_bytes [39:8]
        .s_tuser  (s_tuser),   // command
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // rgb565_word [15:0], dest_index [35:16], zero [39:36]
        .m_tlast  (m_tlast),   // last_pixel
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Palette loads update the table; pixels yield one frame-buffer word each.
    function automatic void bmp_convert(input t_src_item it);
        int unsigned w;
        int unsigned h;
        int unsigned pitch;
        int unsigned idx;
        logic [23:0] rgb;
        t_fb_word    fw;
        if (it.cmd == CMD_PALETTE) begin
            pal_mem[it.slot] = it.bytes[23:0];
            return;
        end
        w = (cfg_width == 0) ? 1 : ((cfg_width > LIMIT_W) ? LIMIT_W : cfg_width);
        h = (cfg_height == 0) ? 1 : ((cfg_height > LIMIT_H) ? LIMIT_H : cfg_height);
        pitch = (w + 3) & 32'hFFFF_FFFC;
        case (cfg_mode)
            MODE_INDEXED: rgb = pal_mem[it.bytes[7:0]];
            default:      rgb = it.bytes[23:0];
        endcase
        if (cfg_mode == MODE_RGB565)
            fw.rgb = it.bytes[15:0];
        else
            fw.rgb = {rgb[23:19], rgb[15:10], rgb[7:3]};
        idx = (h - 1 - row_cnt) * pitch + col_cnt;
        fw.idx = idx[19:0];
        fw.last = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
        due_words.push_back(fw);
    endfunction

    function automatic logic [10:0] pick_extreme();
        case ($urandom_range(0, 7))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd4;
            3:       return 11'd5;
            4:       return 11'd1023;
            5:       return 11'd1024;
            6:       return 11'd1025;
            default: return 11'd2047;
        endcase
    endfunction

    task automatic push_item(input logic cmd, input logic [7:0] slot, input logic [31:0] bytes);
        t_src_item it;
        it.cmd = cmd;
        it.slot = slot;
        it.bytes = bytes;
        if (cmd == CMD_PALETTE && !pal_known[slot]) begin
            pal_known[slot] = 1'b1;
            pal_slots.push_back(slot);
        end
        src_items.push_back(it);
    endtask

    // Indexed pixels only ever point at palette entries loaded earlier in the stream.
    task automatic add_pixel(input t_pixel_mode m);
        logic [31:0] bytes;
        bytes = $urandom;
        if (m == MODE_INDEXED)
            bytes[7:0] = pal_slots[$urandom_range(0, pal_slots.size() - 1)];
        push_item(CMD_PIXEL, 8'($urandom), bytes);
    endtask

    task automatic apb_write(input logic [1:0] ridx, input logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (ridx)
            REG_PIXEL_MODE: cfg_mode = t_pixel_mode'(v[1:0]);
            REG_IMAGE_WIDTH: begin
                cfg_width = v[10:0];
                col_cnt = 0;
                row_cnt = 0;
            end
            REG_IMAGE_HEIGHT: begin
                cfg_height = v[10:0];
                col_cnt = 0;
                row_cnt = 0;
            end
            default: ;
        endcase
    endtask

    // Palette loads give no word out, so the task goes on waiting after the last word for the pipeline to empty.
    task automatic wait_drained();
        while (src_items.size() != 0 || item_held || due_words.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // geo: bit 0 writes the width, bit 1 the height. Upper data bits are random.
    task automatic start_setting(input t_pixel_mode m, input logic [10:0] w,
                                 input logic [10:0] h, input int geo, input int pct);
        logic [31:0] v;
        wait_drained();
        idle_pct = pct;
        v = $urandom;
        v[1:0] = m;
        apb_write(REG_PIXEL_MODE, v);
        if (geo[0]) begin
            v = $urandom;
            v[10:0] = w;
            apb_write(REG_IMAGE_WIDTH, v);
        end
        if (geo[1]) begin
            v = $urandom;
            v[10:0] = h;
            apb_write(REG_IMAGE_HEIGHT, v);
        end
        if ($urandom_range(0, 3) == 0)
            apb_write(REG_UNUSED, $urandom);
        n_settings++;
    endtask

    // Source side: one word is held on the bus until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            item_held = 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                bmp_convert(held_item);
                if (held_item.cmd == CMD_PALETTE)
                    n_palette++;
                item_held = 1'b0;
            end
            if (!item_held) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (src_items.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if ($urandom_range(0, 99) < idle_pct) begin
                    src_gap = $urandom_range(0, 13);
                    s_tvalid <= 1'b0;
                end else begin
                    held_item = src_items.pop_front();
                    item_held = 1'b1;
                    s_tdata  <= {held_item.bytes, held_item.slot};
                    s_tuser  <= held_item.cmd;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Sink side: check each word taken, then decide on back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_words.size() == 0) begin
                    $error("output word with no pixel pending: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = due_words.pop_front();
                    n_pixels++;
                    if (m_tlast)
                        n_last++;
                    if (m_tdata[15:0] !== want.rgb) begin
                        $error("rgb565_word: expected %h, got %h", want.rgb, m_tdata[15:0]);
                        fail_count++;
                    end
                    if (m_tdata[35:16] !== want.idx) begin
                        $error("dest_index: expected %0d, got %0d", want.idx, m_tdata[35:16]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_pixel: expected %b, got %b", want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[39:36] !== 4'd0) begin
                        $error("tdata padding: expected 0, got %h", m_tdata[39:36]);
                        fail_count++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                snk_gap = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_MAX) begin
                $display("Timed out after %0d cycles without a transfer.", STALL_MAX);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_pixel_mode m;
        logic [10:0] w;
        logic [10:0] h;
        int          geo;
        int          n;
        int          pct;
        int          budget;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Indexed, width written as zero: every pixel is a one-pixel image.
        start_setting(MODE_INDEXED, 11'd0, 11'd1, 3, 0);
        push_item(CMD_PALETTE, 8'd0, 32'hFF00_0000);
        push_item(CMD_PALETTE, 8'd255, 32'h00FF_FFFF);
        push_item(CMD_PALETTE, 8'h5A, 32'hAA5A_C33C);
        push_item(CMD_PIXEL, 8'hFF, 32'hFFFF_FF00);
        push_item(CMD_PIXEL, 8'h00, 32'h0000_00FF);
        push_item(CMD_PIXEL, 8'($urandom), 32'h1234_565A);

        // Pass-through with a 3 x 2 image, pitch rounded up to 4.
        start_setting(MODE_RGB565, 11'd3, 11'd2, 3, 0);
        push_item(CMD_PIXEL, 8'($urandom), 32'hFFFF_0000);
        push_item(CMD_PIXEL, 8'($urandom), 32'h0000_FFFF);
        push_item(CMD_PIXEL, 8'($urandom), 32'hA5A5_5A5A);
        push_item(CMD_PIXEL, 8'($urandom), 32'h1234_8001);
        push_item(CMD_PIXEL, 8'($urandom), 32'hFFFF_FFFF);
        push_item(CMD_PIXEL, 8'($urandom), 32'h0000_0000);

        // Dimensions above the maximum are clamped.
        start_setting(MODE_BGR24, 11'd2047, 11'd2047, 3, 30);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        push_item(CMD_PIXEL, 8'($urandom), 32'hFFFF_FFFF);
        push_item(CMD_PIXEL, 8'($urandom), 32'h0000_0000);
        push_item(CMD_PIXEL, 8'($urandom), 32'h00FF_FFFF);
        push_item(CMD_PIXEL, 8'($urandom), 32'hFF00_0000);

        start_setting(MODE_BGRX32, 11'd1024, 11'd1, 3, 30);
        push_item(CMD_PIXEL, 8'($urandom), 32'h8080_8080);
        push_item(CMD_PIXEL, 8'($urandom), 32'h7F7F_7F7F);
        push_item(CMD_PALETTE, 8'h81, 32'h0007_0307);
        push_item(CMD_PIXEL, 8'($urandom), 32'h00F8_FCF8);

        // A mode write alone leaves the image position where it was.
        start_setting(MODE_INDEXED, 11'd0, 11'd0, 0, 30);
        push_item(CMD_PIXEL, 8'($urandom), 32'h0000_0081);
        push_item(CMD_PIXEL, 8'($urandom), 32'hFFFF_FF5A);
        push_item(CMD_PIXEL, 8'($urandom), 32'h1111_11FF);

        budget = 0;
        while (budget < 500) begin
            m = t_pixel_mode'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: begin
                    w = pick_extreme();
                    h = 11'($urandom_range(1, 6));
                end
                1: begin
                    w = 11'($urandom_range(1, 6));
                    h = pick_extreme();
                end
                default: begin
                    w = 11'($urandom_range(1, 12));
                    h = 11'($urandom_range(1, 8));
                end
            endcase
            geo = $urandom_range(0, 5);
            if (geo > 3)
                geo = 3;
            case ($urandom_range(0, 2))
                0:       pct = 0;
                1:       pct = 10;
                default: pct = 30;
            endcase
            if (budget >= 420)
                pct = 0;
            n = $urandom_range(10, 60);
            start_setting(m, w, h, geo, pct);
            repeat (n) begin
                if ($urandom_range(0, 99) < 12)
                    push_item(CMD_PALETTE, 8'($urandom), $urandom);
                else
                    add_pixel(m);
            end
            budget += n;
        end

        wait_drained();
        $display("Checked %0d RGB565 words, %0d of them image ends, after %0d palette loads.",
                 n_pixels, n_last, n_palette);
        $display("Stream ran under %0d register settings across all four pixel modes.",
                 n_settings);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
